@@ hdl/sha256_byte_stream_hash_assert.svh @@
// Assertion macros for the SHA-256 byte stream hasher module.
// Used by files that include this header; no other dependencies.
`ifndef SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_ASSERT_SVH

// Property that must hold on every rising clock edge outside reset.
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/sha256_pkg.sv @@
// Package for the SHA-256 byte stream hasher: sequencer states, IV and round constants.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	// Why a compression was started; decides what follows it.
	typedef enum logic [1:0] {
		CAUSE_FULL,
		CAUSE_FULL_LAST,
		CAUSE_PAD_EXTRA,
		CAUSE_FINAL
	} cause_t;

	typedef logic [31:0] word_t;

	function automatic word_t sha_iv(input logic [2:0] idx);
		word_t v;
		begin
			unique case (idx)
				3'd0: v = 32'h6A09E667;
				3'd1: v = 32'hBB67AE85;
				3'd2: v = 32'h3C6EF372;
				3'd3: v = 32'hA54FF53A;
				3'd4: v = 32'h510E527F;
				3'd5: v = 32'h9B05688C;
				3'd6: v = 32'h1F83D9AB;
				default: v = 32'h5BE0CD19;
			endcase
			return v;
		end
	endfunction

	localparam word_t SHA_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

endpackage

@@ hdl/sha256_round.sv @@
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round
	import sha256_pkg::*;
(
	input  word_t       a_in [8],
	input  word_t       w_in [16],
	input  logic [5:0]  rnd,
	output word_t       a_out [8],
	output word_t       w_next
);

	word_t s0, s1, ch, maj, t1, t2, ws0, ws1;

	always_comb begin
		s1  = {a_in[4][5:0], a_in[4][31:6]} ^ {a_in[4][10:0], a_in[4][31:11]}
			^ {a_in[4][24:0], a_in[4][31:25]};
		s0  = {a_in[0][1:0], a_in[0][31:2]} ^ {a_in[0][12:0], a_in[0][31:13]}
			^ {a_in[0][21:0], a_in[0][31:22]};
		ch  = (a_in[4] & a_in[5]) ^ (~a_in[4] & a_in[6]);
		maj = (a_in[0] & a_in[1]) ^ (a_in[0] & a_in[2]) ^ (a_in[1] & a_in[2]);
		t1  = a_in[7] + s1 + ch + SHA_K[rnd] + w_in[0];
		t2  = s0 + maj;
		a_out[7] = a_in[6];
		a_out[6] = a_in[5];
		a_out[5] = a_in[4];
		a_out[4] = a_in[3] + t1;
		a_out[3] = a_in[2];
		a_out[2] = a_in[1];
		a_out[1] = a_in[0];
		a_out[0] = t1 + t2;
		// The window holds w[t..t+15]; the word entering it is w[t+16].
		ws0 = {w_in[1][6:0], w_in[1][31:7]} ^ {w_in[1][17:0], w_in[1][31:18]}
			^ (w_in[1] >> 3);
		ws1 = {w_in[14][16:0], w_in[14][31:17]} ^ {w_in[14][18:0], w_in[14][31:19]}
			^ (w_in[14] >> 10);
		w_next = ws1 + w_in[9] + ws0 + w_in[0];
	end

endmodule

@@ hdl/sha256_byte_stream_hash.sv @@
// SHA-256 byte stream hasher: one byte per transaction, digest as eight words.
// A byte that fills a block starts a compression of 64 rounds and an add step.
// A last transaction adds a padding step and one or two compressions, then
// the eight digest words, each held until out_ready. Other bytes are taken
// while the hasher is idle; no byte is taken while a block is compressed or
// the digest goes out, so the round unit is the limit over a long message.
// Asynchronous reset returns the chain to the initial hash values with an empty message.
`timescale 1ns / 1ps

module sha256_byte_stream_hash
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        has_byte,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_pos,
	output logic        last_word
);

`include "sha256_byte_stream_hash_assert.svh"

	state_t state_q, state_d;
	cause_t cause_q;
	word_t  chain_q [8];
	word_t  a_q [8];
	word_t  w_q [16];
	word_t  a_nx [8];
	word_t  w_nx;
	logic [5:0]  rnd_q;
	logic [5:0]  nbytes_q;
	logic [63:0] bits_q;
	logic [2:0]  oidx_q;
	logic        acc;

	sha256_round u_round (
		.a_in  (a_q),
		.w_in  (w_q),
		.rnd   (rnd_q),
		.a_out (a_nx),
		.w_next(w_nx)
	);

	assign acc = valid && ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (has_byte && nbytes_q == 6'd63) state_d = ST_ROUND;
					else if (last_byte) state_d = ST_PAD;
				end
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
			ST_ADD: begin
				unique case (cause_q)
					CAUSE_FULL:      state_d = ST_IDLE;
					CAUSE_FULL_LAST: state_d = ST_PAD;
					CAUSE_PAD_EXTRA: state_d = ST_ROUND;
					default:         state_d = ST_OUT;
				endcase
			end
			ST_PAD:  state_d = ST_ROUND;
			ST_OUT:  if (out_ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready       = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_OUT);
		digest_word = chain_q[oidx_q];
		word_pos    = oidx_q;
		last_word   = (oidx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cause_q  <= CAUSE_FULL;
			rnd_q    <= '0;
			nbytes_q <= '0;
			bits_q   <= '0;
			oidx_q   <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
			for (int i = 0; i < 8; i++) a_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (acc && has_byte) begin
						w_q[nbytes_q[5:2]] <= w_q[nbytes_q[5:2]]
							| (word_t'(data_byte) << (5'd24 - {nbytes_q[1:0], 3'b000}));
						nbytes_q <= nbytes_q + 6'd1;
						bits_q   <= bits_q + 64'd8;
					end
					if (acc && has_byte && nbytes_q == 6'd63) begin
						// A full block is compressed; if this byte is the last, padding goes in a block of its own.
						cause_q <= last_byte ? CAUSE_FULL_LAST : CAUSE_FULL;
						for (int i = 0; i < 8; i++) a_q[i] <= chain_q[i];
						rnd_q <= '0;
					end
				end
				ST_PAD: begin
					// Data bytes are in place; nbytes_q points past the last of them.
					w_q[nbytes_q[5:2]] <= w_q[nbytes_q[5:2]]
						| (32'h80 << (5'd24 - {nbytes_q[1:0], 3'b000}));
					if (nbytes_q <= 6'd55) begin
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						cause_q <= CAUSE_FINAL;
					end else begin
						cause_q <= CAUSE_PAD_EXTRA;
					end
					for (int i = 0; i < 8; i++) a_q[i] <= chain_q[i];
					rnd_q <= '0;
				end
				ST_ROUND: begin
					for (int i = 0; i < 8; i++) a_q[i] <= a_nx[i];
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_nx;
					rnd_q   <= rnd_q + 6'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + a_q[i];
					for (int i = 0; i < 16; i++) w_q[i] <= '0;
					nbytes_q <= '0;
					if (cause_q == CAUSE_PAD_EXTRA) begin
						// Second block carries zeros and the length only.
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						cause_q <= CAUSE_FINAL;
						for (int i = 0; i < 8; i++) a_q[i] <= chain_q[i] + a_q[i];
						rnd_q <= '0;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
							bits_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`SHA_ASSERT(a_busy_excl, clk, arst_n, !(ready && out_valid), "ready while output valid")
	`SHA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(word_pos), "output dropped while stalled")
	`SHA_ASSERT_NEXT(a_round_end, clk, arst_n, state_q == ST_ROUND && rnd_q == 6'd63, state_q == ST_ADD, "round count overrun")
	`SHA_ASSERT(a_idx_idle, clk, arst_n, state_q == ST_OUT || oidx_q == 3'd0, "word index not cleared")

endmodule
